// File: rtl/core/page_table_permission_walker_assert.svh
`ifndef PAGE_TABLE_PERMISSION_WALKER_ASSERT_SVH
`define PAGE_TABLE_PERMISSION_WALKER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define PTPW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page table walker assertion failed");

// Next-cycle implication, disabled in reset
`define PTPW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page table walker assertion failed");

`endif

// File: rtl/core/ptpw_pkg.sv
package ptpw_pkg;

    localparam int STORE_WORDS    = 4096;
    localparam int PHYS_ADDR_BITS = 36;
    localparam int STORE_AW       = $clog2(STORE_WORDS);
    localparam int WORD_BITS      = PHYS_ADDR_BITS - 3;
    localparam int ROOT_BITS      = 36;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 64;
    localparam int LVL_BITS       = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TABLE_ROOT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIVE_LEVEL = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLE_LOW   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLE_HIGH  = 2'd3;

    localparam logic [63:0] HOLE_LOW_RESET  = 64'h0000_0000_8300_0000;
    localparam logic [63:0] HOLE_HIGH_RESET = 64'h0000_0000_87C0_0000;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_RO   = 2'd1;
    localparam logic [1:0] ACC_RW   = 2'd2;

    localparam int PTE_PRESENT = 0;
    localparam int PTE_RW      = 1;
    localparam int PTE_LARGE   = 7;

    localparam logic [LVL_BITS-1:0] LVL_PT   = 3'd0;
    localparam logic [LVL_BITS-1:0] LVL_PD   = 3'd1;
    localparam logic [LVL_BITS-1:0] LVL_PDPT = 3'd2;
    localparam logic [LVL_BITS-1:0] LVL_PML4 = 3'd3;
    localparam logic [LVL_BITS-1:0] LVL_PML5 = 3'd4;

    typedef struct packed {
        logic        func;
        logic [63:0] virt_addr;
        logic [11:0] entry_slot;
        logic [63:0] entry_data;
    } walk_cmd_t;

    typedef struct packed {
        logic [1:0] access;
        logic       readable;
        logic       writable;
        logic       out_of_store;
    } walk_result_t;

    function automatic logic [PHYS_ADDR_BITS-1:0] root_base(input logic [ROOT_BITS-1:0] root);
        logic [63:0] w;
        w = 64'(root);
        return {w[PHYS_ADDR_BITS-1:12], 12'h000};
    endfunction

    function automatic logic [PHYS_ADDR_BITS-1:0] entry_base(input logic [63:0] e);
        return {e[PHYS_ADDR_BITS-1:12], 12'h000};
    endfunction

    function automatic logic [8:0] level_index(input logic [63:0] va,
                                               input logic [LVL_BITS-1:0] lvl);
        logic [8:0] idx;
        case (lvl)
            LVL_PML5: idx = va[56:48];
            LVL_PML4: idx = va[47:39];
            LVL_PDPT: idx = va[38:30];
            LVL_PD:   idx = va[29:21];
            default:  idx = va[20:12];
        endcase
        return idx;
    endfunction

    function automatic walk_result_t make_result(input logic [1:0] acc, input logic oos);
        walk_result_t r;
        r.access       = acc;
        r.readable     = (acc != ACC_NONE);
        r.writable     = (acc == ACC_RW);
        r.out_of_store = oos;
        return r;
    endfunction

endpackage

// File: rtl/core/ptpw_ram.sv
module ptpw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/core/page_table_permission_walker.sv
// Page-table permission walker. A transaction is accepted when start is high and busy is low.
// A write transaction (func 0) loads one 64-bit entry into the table store in its accept cycle
// and returns no result; busy stays low. A check transaction (func 1) walks the x86-64 tables
// from table_root, reading one entry per level (four in four-level mode, five in five-level
// mode, fewer when the walk stops early): a setup state first for the window and root checks,
// then the levels in turn, one after another because of the single port of the store memory
// and its registered read, each level's address depending on the entry before. The result is
// shown on result with done high for exactly one cycle and cannot be held off. After reset the
// store is cleared, one word a cycle, through all STORE_WORDS (4096) words with busy high;
// configuration writes are taken meanwhile.
// Configuration registers may be written only while no check transaction is in flight.
module page_table_permission_walker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  ptpw_pkg::walk_cmd_t                   cmd,
    input  logic                                  cfg_we,
    input  logic [ptpw_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ptpw_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output logic                                  done,
    output ptpw_pkg::walk_result_t                result
);

    import ptpw_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_WALK
    } state_t;

    localparam logic [STORE_AW-1:0] CLR_LAST = STORE_AW'(STORE_WORDS - 1);

    state_t                  state_reg, state_next;
    logic [LVL_BITS-1:0]     lvl_reg, lvl_next;
    logic [STORE_AW-1:0]     clr_reg, clr_next;
    logic                    done_reg, done_next;
    walk_result_t            result_reg, result_next;
    logic [63:0]             va_reg;

    logic [ROOT_BITS-1:0]    table_root_reg;
    logic                    five_level_reg;
    logic [63:0]             hole_low_reg;
    logic [63:0]             hole_high_reg;

    logic                    accept;
    logic [31:0]             slot_w;
    logic                    slot_in_store;
    logic [PHYS_ADDR_BITS-1:0] root_w;
    logic [63:0]             entry;
    logic [LVL_BITS-1:0]     walk_lvl;
    logic [PHYS_ADDR_BITS-1:0] walk_base;
    logic [8:0]              walk_idx;
    logic [PHYS_ADDR_BITS-1:0] pa;
    logic [WORD_BITS-1:0]    word;
    logic                    pa_zero;
    logic                    pa_oos;
    logic                    in_hole;
    logic                    leaf;
    logic [1:0]              leaf_acc;

    logic                    mem_we;
    logic [STORE_AW-1:0]     mem_addr;
    logic [63:0]             mem_wdata;

    ptpw_ram #(
        .WIDTH (64),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (entry)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign slot_w        = 32'(cmd.entry_slot);
    assign slot_in_store = (slot_w < 32'(STORE_WORDS));
    assign root_w        = root_base(table_root_reg);
    assign in_hole       = (va_reg >= hole_low_reg) && (va_reg <= hole_high_reg);

    always_comb
    begin
        if (state_reg == S_CHECK)
        begin
            walk_lvl  = five_level_reg ? LVL_PML5 : LVL_PML4;
            walk_base = root_w;
        end
        else
        begin
            walk_lvl  = lvl_reg - 3'd1;
            walk_base = entry_base(entry);
        end
    end

    assign walk_idx = level_index(va_reg, walk_lvl);
    assign pa       = {walk_base[PHYS_ADDR_BITS-1:12], walk_idx, 3'b000};
    assign word     = pa[PHYS_ADDR_BITS-1:3];
    assign pa_zero  = (pa == '0);
    assign pa_oos   = (word >= WORD_BITS'(STORE_WORDS));

    assign leaf     = (lvl_reg == LVL_PT)
                   || (((lvl_reg == LVL_PD) || (lvl_reg == LVL_PDPT)) && entry[PTE_LARGE]);
    assign leaf_acc = entry[PTE_RW] ? ACC_RW : ACC_RO;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = word[STORE_AW-1:0];
        mem_wdata = cmd.entry_data;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
            end
            S_IDLE:
            begin
                mem_we   = accept && (cmd.func == FUNC_WRITE) && slot_in_store;
                mem_addr = slot_w[STORE_AW-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        lvl_next    = lvl_reg;
        clr_next    = clr_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && (cmd.func == FUNC_CHECK))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                lvl_next = walk_lvl;
                if ((va_reg == '0) || in_hole || (root_w == '0) || pa_zero || pa_oos)
                begin
                    done_next   = 1'b1;
                    result_next = make_result(ACC_NONE,
                                              pa_oos && (va_reg != '0) && !in_hole
                                              && (root_w != '0));
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                lvl_next = walk_lvl;
                if (!entry[PTE_PRESENT])
                begin
                    done_next   = 1'b1;
                    result_next = make_result(ACC_NONE, 1'b0);
                    state_next  = S_IDLE;
                end
                else if (leaf)
                begin
                    done_next   = 1'b1;
                    result_next = make_result(leaf_acc, 1'b0);
                    state_next  = S_IDLE;
                end
                else if (pa_zero || pa_oos)
                begin
                    done_next   = 1'b1;
                    result_next = make_result(ACC_NONE, pa_oos);
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            lvl_reg    <= LVL_PT;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            lvl_reg    <= lvl_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            va_reg <= cmd.virt_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_root_reg <= '0;
            five_level_reg <= 1'b0;
            hole_low_reg   <= HOLE_LOW_RESET;
            hole_high_reg  <= HOLE_HIGH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TABLE_ROOT: table_root_reg <= cfg_data[ROOT_BITS-1:0];
                REG_FIVE_LEVEL: five_level_reg <= cfg_data[0];
                REG_HOLE_LOW:   hole_low_reg   <= cfg_data;
                REG_HOLE_HIGH:  hole_high_reg  <= cfg_data;
                default:        five_level_reg <= five_level_reg;
            endcase
        end
    end

endmodule

// File: rtl/core/ptpw_checker.sv
`include "page_table_permission_walker_assert.svh"

module ptpw_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  ptpw_pkg::walk_cmd_t    cmd,
    input  logic                   done,
    input  ptpw_pkg::walk_result_t result
);

    import ptpw_pkg::*;

    logic wr_accept;
    logic chk_accept;
    logic result_ok;

    assign wr_accept  = start && !busy && (cmd.func == FUNC_WRITE);
    assign chk_accept = start && !busy && (cmd.func == FUNC_CHECK);
    assign result_ok  = (result.readable == (result.access != ACC_NONE))
                     && (result.writable == (result.access == ACC_RW))
                     && (!result.out_of_store || (result.access == ACC_NONE));

    `PTPW_ASSERT_IMP(a_done_ends_walk, clk, rst_n, done, $past(busy))
    `PTPW_ASSERT_NXT(a_done_single, clk, rst_n, done, !done)
    `PTPW_ASSERT_NXT(a_write_no_result, clk, rst_n, wr_accept, !busy && !done)
    `PTPW_ASSERT_NXT(a_check_goes_busy, clk, rst_n, chk_accept, busy && !done)
    `PTPW_ASSERT_IMP(a_result_coherent, clk, rst_n, done, result_ok)

endmodule

bind page_table_permission_walker ptpw_checker u_ptpw_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
);
